// ===== rtl/core/swc_pkg.sv =====
// ============================================================================
// swc_pkg: shared types and helpers for the segment window clipper
// Fixed-point widths, payload structs, register indexes and point compares.
// ============================================================================
package swc_pkg;

    localparam int CW      = 32;          // coordinate width
    localparam int FB      = 16;          // fraction bits
    localparam int TW      = 16;          // tolerance width
    localparam int DW      = CW + 1;      // coordinate difference width
    localparam int PW      = 2 * DW;      // product width
    localparam int NW      = PW + 1;      // sum of two products
    localparam int QHW     = NW - CW;     // dividend bits above the quotient
    localparam int DIV_LAT = CW + 3;      // divider latency in cycles
    localparam int CFG_AW  = 3;

    typedef enum logic [CFG_AW-1:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_BOTTOM = 3'd1,
        REG_WIN_RIGHT  = 3'd2,
        REG_WIN_TOP    = 3'd3,
        REG_TOLERANCE  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [CW-1:0] seg_x_a;
        logic signed [CW-1:0] seg_y_a;
        logic signed [CW-1:0] seg_x_b;
        logic signed [CW-1:0] seg_y_b;
    } t_seg_in;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] clip_x_a;
        logic signed [CW-1:0] clip_y_a;
        logic signed [CW-1:0] clip_x_b;
        logic signed [CW-1:0] clip_y_b;
    } t_seg_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] top;
        logic [TW-1:0]        tol;
    } t_win;

    // Segment endpoints and the two points where its line meets the window.
    typedef struct packed {
        t_pt  p1;
        t_pt  p2;
        t_pt  c1;
        t_pt  c2;
        logic ok;
    } t_clip_job;

    function automatic logic [DW-1:0] tol_ext(input logic [TW-1:0] tol);
        tol_ext = DW'(tol);
    endfunction

    // Both coordinate differences within the tolerance, bounds included.
    function automatic logic pt_same(input t_pt p, input t_pt q, input logic [TW-1:0] tol);
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] tl;
        dx = DW'(p.x) - DW'(q.x);
        dy = DW'(p.y) - DW'(q.y);
        tl = $signed(tol_ext(tol));
        pt_same = (dx <= tl) && (dx >= -tl) && (dy <= tl) && (dy >= -tl);
    endfunction

    // Both coordinate differences strictly inside the tolerance.
    function automatic logic pt_near(input t_pt p, input t_pt q, input logic [TW-1:0] tol);
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] tl;
        dx = DW'(p.x) - DW'(q.x);
        dy = DW'(p.y) - DW'(q.y);
        tl = $signed(tol_ext(tol));
        pt_near = (dx < tl) && (dx > -tl) && (dy < tl) && (dy > -tl);
    endfunction

endpackage

// ===== rtl/core/swc_div.sv =====
// ============================================================================
// swc_div: pipelined signed divider
// Truncating quotient of a wide product sum by a coordinate difference, one
// quotient bit per stage, saturated to the coordinate range.
// ============================================================================
module swc_div import swc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [CW-1:0] o_quo,
    output logic                 o_ok
);

    logic [NW-1:0] n_nmag;
    logic [DW-1:0] n_dmag;
    logic [NW-1:0] r0_n;
    logic [DW-1:0] r0_d;
    logic          r0_neg;

    logic [DW-1:0] r_rem  [0:CW];
    logic [CW-1:0] r_low  [0:CW];
    logic [CW-1:0] r_q    [0:CW];
    logic [DW-1:0] r_d    [0:CW];
    logic          r_neg  [0:CW];
    logic          r_ovf  [0:CW];
    logic          r_zero [0:CW];

    logic [CW-1:0] n_lim;
    logic [CW-1:0] n_mag;
    logic          n_sat;
    logic signed [CW-1:0] r_quo;
    logic          r_ok;

    assign n_nmag = i_num[NW-1] ? -i_num : i_num;
    assign n_dmag = i_den[DW-1] ? -i_den : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_n   <= n_nmag;
            r0_d   <= n_dmag;
            r0_neg <= i_num[NW-1] ^ i_den[DW-1];
        end
    end

    // A dividend whose upper part reaches the divisor gives a quotient that
    // cannot fit, so those items saturate and the rest need only CW steps.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= r0_n[NW-1:CW] >= QHW'(r0_d);
            r_zero[0] <= (r0_d == '0);
            r_rem[0]  <= r0_n[CW+DW-1:CW];
            r_low[0]  <= r0_n[CW-1:0];
            r_q[0]    <= '0;
            r_d[0]    <= r0_d;
            r_neg[0]  <= r0_neg;
        end
    end

    for (genvar g = 0; g < CW; g++) begin : g_step
        logic [DW:0] trial;
        logic        take;
        logic [DW:0] diff;

        assign trial = {r_rem[g], r_low[g][CW-1]};
        assign diff  = trial - {1'b0, r_d[g]};
        assign take  = trial >= {1'b0, r_d[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
                r_low[g+1]  <= {r_low[g][CW-2:0], 1'b0};
                r_q[g+1]    <= {r_q[g][CW-2:0], take};
                r_d[g+1]    <= r_d[g];
                r_neg[g+1]  <= r_neg[g];
                r_ovf[g+1]  <= r_ovf[g];
                r_zero[g+1] <= r_zero[g];
            end
        end
    end

    assign n_lim = r_neg[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    assign n_sat = r_ovf[CW] || (r_q[CW] > n_lim);
    assign n_mag = n_sat ? n_lim : r_q[CW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok <= !r_zero[CW];
            if (r_zero[CW]) begin
                r_quo <= '0;
            end else if (r_neg[CW]) begin
                r_quo <= -$signed(n_mag);
            end else begin
                r_quo <= $signed(n_mag);
            end
        end
    end

    assign o_quo = r_quo;
    assign o_ok  = r_ok;

endmodule

// ===== rtl/core/swc_line.sv =====
// ============================================================================
// swc_line: line against window
// Intersects the segment's carrier line with the four window edges through
// four pipelined dividers and picks the two window points in edge order.
// ============================================================================
module swc_line import swc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_seg_in   i_seg,
    input  t_win      i_win,
    output logic      o_vld,
    output t_clip_job o_job
);

    typedef struct packed {
        t_pt  p1;
        t_pt  p2;
        logic zero_win;
        logic degen;
    } t_line_side;

    t_line_side n_side;
    logic signed [DW-1:0] n_a, n_b, n_eyb, n_eyt, n_exl, n_exr;

    t_line_side r1_side;
    logic       r1_vld;
    logic signed [DW-1:0] r1_a, r1_b, r1_eyb, r1_eyt, r1_exl, r1_exr;

    t_line_side r2_side;
    logic       r2_vld;
    logic signed [DW-1:0] r2_a, r2_b;
    logic signed [PW-1:0] r2_pax, r2_pby, r2_pbb, r2_pbt, r2_pal, r2_par;

    t_line_side r3_side;
    logic       r3_vld;
    logic signed [DW-1:0] r3_a, r3_b;
    logic signed [NW-1:0] r3_nb, r3_nt, r3_nl, r3_nr;

    logic signed [CW-1:0] w_db, w_dt, w_dl, w_dr;
    logic                 w_okb, w_okt, w_okl, w_okr;

    t_line_side r_dside [0:DIV_LAT-1];
    logic       r_dvld  [0:DIV_LAT-1];

    t_line_side r4_side;
    logic       r4_vld;
    logic signed [CW-1:0] r4_db, r4_dt, r4_dl, r4_dr;
    logic r4_inxb, r4_inxt, r4_inyl, r4_inyr;
    logic r4_same_bl, r4_same_tl, r4_same_tr;

    t_clip_job n_job;
    t_clip_job r5_job;
    logic      r5_vld;

    assign n_side.p1       = t_pt'{x: i_seg.seg_x_a, y: i_seg.seg_y_a};
    assign n_side.p2       = t_pt'{x: i_seg.seg_x_b, y: i_seg.seg_y_b};
    assign n_side.zero_win = (i_win.left == '0) && (i_win.right == '0) &&
                             (i_win.bottom == '0) && (i_win.top == '0);
    assign n_side.degen    = pt_same(n_side.p1, n_side.p2, i_win.tol);

    // Line through A and B: a*x + b*y + c = 0 with a = yb - ya, b = xa - xb.
    assign n_a   = DW'(i_seg.seg_y_b) - DW'(i_seg.seg_y_a);
    assign n_b   = DW'(i_seg.seg_x_a) - DW'(i_seg.seg_x_b);
    assign n_eyb = DW'(i_seg.seg_y_a) - DW'(i_win.bottom);
    assign n_eyt = DW'(i_seg.seg_y_a) - DW'(i_win.top);
    assign n_exl = DW'(i_seg.seg_x_a) - DW'(i_win.left);
    assign n_exr = DW'(i_seg.seg_x_a) - DW'(i_win.right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n_side;
            r1_a    <= n_a;
            r1_b    <= n_b;
            r1_eyb  <= n_eyb;
            r1_eyt  <= n_eyt;
            r1_exl  <= n_exl;
            r1_exr  <= n_exr;

            r2_side <= r1_side;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_pax  <= PW'(r1_a) * PW'(r1_side.p1.x);
            r2_pby  <= PW'(r1_b) * PW'(r1_side.p1.y);
            r2_pbb  <= PW'(r1_b) * PW'(r1_eyb);
            r2_pbt  <= PW'(r1_b) * PW'(r1_eyt);
            r2_pal  <= PW'(r1_a) * PW'(r1_exl);
            r2_par  <= PW'(r1_a) * PW'(r1_exr);

            // x at a horizontal edge Y: (a*xa + b*(ya - Y)) / a
            // y at a vertical edge X:   (a*(xa - X) + b*ya) / b
            r3_side <= r2_side;
            r3_a    <= r2_a;
            r3_b    <= r2_b;
            r3_nb   <= NW'(r2_pax) + NW'(r2_pbb);
            r3_nt   <= NW'(r2_pax) + NW'(r2_pbt);
            r3_nl   <= NW'(r2_pal) + NW'(r2_pby);
            r3_nr   <= NW'(r2_par) + NW'(r2_pby);
        end
    end

    swc_div u_div_bot (
        .i_clk (i_clk), .i_en (i_en), .i_num (r3_nb), .i_den (r3_a),
        .o_quo (w_db), .o_ok (w_okb)
    );
    swc_div u_div_top (
        .i_clk (i_clk), .i_en (i_en), .i_num (r3_nt), .i_den (r3_a),
        .o_quo (w_dt), .o_ok (w_okt)
    );
    swc_div u_div_left (
        .i_clk (i_clk), .i_en (i_en), .i_num (r3_nl), .i_den (r3_b),
        .o_quo (w_dl), .o_ok (w_okl)
    );
    swc_div u_div_right (
        .i_clk (i_clk), .i_en (i_en), .i_num (r3_nr), .i_den (r3_b),
        .o_quo (w_dr), .o_ok (w_okr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else if (i_en) begin
            r_dvld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dside[0] <= r3_side;
        end
    end

    for (genvar g = 1; g < DIV_LAT; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[g] <= 1'b0;
            end else if (i_en) begin
                r_dvld[g] <= r_dvld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dside[g] <= r_dside[g-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r_dvld[DIV_LAT-1];
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side    <= r_dside[DIV_LAT-1];
            r4_db      <= w_db;
            r4_dt      <= w_dt;
            r4_dl      <= w_dl;
            r4_dr      <= w_dr;
            r4_inxb    <= w_okb && (w_db >= i_win.left) && (w_db <= i_win.right);
            r4_inxt    <= w_okt && (w_dt >= i_win.left) && (w_dt <= i_win.right);
            r4_inyl    <= w_okl && (w_dl >= i_win.bottom) && (w_dl <= i_win.top);
            r4_inyr    <= w_okr && (w_dr >= i_win.bottom) && (w_dr <= i_win.top);
            r4_same_bl <= pt_same(t_pt'{x: w_db, y: i_win.bottom},
                                  t_pt'{x: i_win.left, y: w_dl}, i_win.tol);
            r4_same_tl <= pt_same(t_pt'{x: w_dt, y: i_win.top},
                                  t_pt'{x: i_win.left, y: w_dl}, i_win.tol);
            r4_same_tr <= pt_same(t_pt'{x: w_dt, y: i_win.top},
                                  t_pt'{x: i_win.right, y: w_dr}, i_win.tol);
            r5_job     <= n_job;
        end
    end

    // Edges are tried bottom, top, left, right; a bottom-left, top-left or
    // top-right corner taken as the first point is not taken again as the second.
    always_comb begin
        n_job.p1 = r4_side.p1;
        n_job.p2 = r4_side.p2;
        n_job.c1 = r4_side.p1;
        n_job.c2 = r4_side.p2;
        n_job.ok = 1'b1;
        if (!r4_side.zero_win) begin
            if (r4_side.degen) begin
                n_job.ok = 1'b0;
            end else if (r4_inxb) begin
                n_job.c1 = t_pt'{x: r4_db, y: i_win.bottom};
                if (r4_inxt) begin
                    n_job.c2 = t_pt'{x: r4_dt, y: i_win.top};
                end else if (r4_inyl && !r4_same_bl) begin
                    n_job.c2 = t_pt'{x: i_win.left, y: r4_dl};
                end else if (r4_inyr) begin
                    n_job.c2 = t_pt'{x: i_win.right, y: r4_dr};
                end else begin
                    n_job.ok = 1'b0;
                end
            end else if (r4_inxt) begin
                n_job.c1 = t_pt'{x: r4_dt, y: i_win.top};
                if (r4_inyl && !r4_same_tl) begin
                    n_job.c2 = t_pt'{x: i_win.left, y: r4_dl};
                end else if (r4_inyr && !r4_same_tr) begin
                    n_job.c2 = t_pt'{x: i_win.right, y: r4_dr};
                end else begin
                    n_job.ok = 1'b0;
                end
            end else if (r4_inyl) begin
                n_job.c1 = t_pt'{x: i_win.left, y: r4_dl};
                n_job.c2 = t_pt'{x: i_win.right, y: r4_dr};
            end else begin
                n_job.ok = 1'b0;
            end
        end
    end

    assign o_vld = r5_vld;
    assign o_job = r5_job;

endmodule

// ===== rtl/core/swc_betw.sv =====
// ============================================================================
// swc_betw: betweenness test
// Checks that q lies on the segment from p to r within tolerance: collinear,
// ordered along both axes, and not merely close to one end of a long span.
// ============================================================================
module swc_betw import swc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  t_pt           i_p,
    input  t_pt           i_q,
    input  t_pt           i_r,
    input  logic [TW-1:0] i_tol,
    output logic          o_ok
);

    logic signed [DW-1:0] r1_dx1, r1_dy1, r1_dx2, r1_dy2;
    logic                 r1_npq, r1_nrq, r1_npr;
    logic [TW-1:0]        r1_tol, r2_tol;

    logic signed [PW-1:0] r2_mcr1, r2_mcr2, r2_mdx, r2_mdy;
    logic                 r2_nfail;

    logic signed [NW-1:0] n_cr;
    logic signed [NW-1:0] n_t2;
    logic                 r3_cr_ok, r3_dx_ok, r3_dy_ok, r3_nfail;

    assign n_cr = NW'(r2_mcr1) - NW'(r2_mcr2);
    assign n_t2 = $signed(NW'({r2_tol, {FB{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx1 <= DW'(i_p.x) - DW'(i_q.x);
            r1_dy1 <= DW'(i_p.y) - DW'(i_q.y);
            r1_dx2 <= DW'(i_q.x) - DW'(i_r.x);
            r1_dy2 <= DW'(i_q.y) - DW'(i_r.y);
            r1_npq <= pt_near(i_p, i_q, i_tol);
            r1_nrq <= pt_near(i_r, i_q, i_tol);
            r1_npr <= pt_near(i_p, i_r, i_tol);
            r1_tol <= i_tol;

            r2_mcr1  <= PW'(r1_dx1) * PW'(r1_dy2);
            r2_mcr2  <= PW'(r1_dy1) * PW'(r1_dx2);
            r2_mdx   <= PW'(r1_dx1) * PW'(r1_dx2);
            r2_mdy   <= PW'(r1_dy1) * PW'(r1_dy2);
            r2_nfail <= (r1_npq || r1_nrq) && !r1_npr;
            r2_tol   <= r1_tol;

            r3_cr_ok <= (n_cr <= n_t2) && (n_cr >= -n_t2);
            r3_dx_ok <= !(NW'(r2_mdx) < -n_t2);
            r3_dy_ok <= !(NW'(r2_mdy) < -n_t2);
            r3_nfail <= r2_nfail;
        end
    end

    assign o_ok = r3_cr_ok && r3_dx_ok && r3_dy_ok && !r3_nfail;

endmodule

// ===== rtl/core/swc_seg.sv =====
// ============================================================================
// swc_seg: segment against window span
// Runs seven betweenness tests side by side and keeps the part of the
// window span that lies inside the original segment.
// ============================================================================
module swc_seg import swc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_clip_job i_job,
    input  t_win      i_win,
    output logic      o_vld,
    output t_seg_out  o_res
);

    typedef struct packed {
        logic p1c1;
        logic p1c2;
        logic p2c1;
        logic p2c2;
    } t_near;

    t_clip_job r_job [0:2];
    t_near     r_nr  [0:2];
    logic      r_vld [0:2];

    // Betweenness is symmetric in its end points, so seven tests cover
    // every branch.
    logic b_p1_p2_c2, b_p1_c2_p2, b_p1_p2_c1, b_p1_c1_p2;
    logic b_p2_p1_c2, b_p2_p1_c1, b_c1_p1_c2;

    t_clip_job w_j;
    t_near     w_n;
    logic      n_vis;
    t_pt       n_o1, n_o2;

    swc_betw u_b0 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.p1), .i_q(i_job.p2),
                   .i_r(i_job.c2), .i_tol(i_win.tol), .o_ok(b_p1_p2_c2));
    swc_betw u_b1 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.p1), .i_q(i_job.c2),
                   .i_r(i_job.p2), .i_tol(i_win.tol), .o_ok(b_p1_c2_p2));
    swc_betw u_b2 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.p1), .i_q(i_job.p2),
                   .i_r(i_job.c1), .i_tol(i_win.tol), .o_ok(b_p1_p2_c1));
    swc_betw u_b3 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.p1), .i_q(i_job.c1),
                   .i_r(i_job.p2), .i_tol(i_win.tol), .o_ok(b_p1_c1_p2));
    swc_betw u_b4 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.p2), .i_q(i_job.p1),
                   .i_r(i_job.c2), .i_tol(i_win.tol), .o_ok(b_p2_p1_c2));
    swc_betw u_b5 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.p2), .i_q(i_job.p1),
                   .i_r(i_job.c1), .i_tol(i_win.tol), .o_ok(b_p2_p1_c1));
    swc_betw u_b6 (.i_clk(i_clk), .i_en(i_en), .i_p(i_job.c1), .i_q(i_job.p1),
                   .i_r(i_job.c2), .i_tol(i_win.tol), .o_ok(b_c1_p1_c2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
            r_vld[2] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_job[0]      <= i_job;
            r_nr[0].p1c1  <= pt_near(i_job.p1, i_job.c1, i_win.tol);
            r_nr[0].p1c2  <= pt_near(i_job.p1, i_job.c2, i_win.tol);
            r_nr[0].p2c1  <= pt_near(i_job.p2, i_job.c1, i_win.tol);
            r_nr[0].p2c2  <= pt_near(i_job.p2, i_job.c2, i_win.tol);
            r_job[1]      <= r_job[0];
            r_nr[1]       <= r_nr[0];
            r_job[2]      <= r_job[1];
            r_nr[2]       <= r_nr[1];
        end
    end

    assign w_j = r_job[2];
    assign w_n = r_nr[2];

    always_comb begin
        n_vis = w_j.ok;
        n_o1  = w_j.p1;
        n_o2  = w_j.p2;
        if (!w_j.ok) begin
            n_vis = 1'b0;
        end else if (w_n.p1c1) begin
            if (!(b_p1_p2_c2 || w_n.p2c2)) begin
                if (b_p1_c2_p2) begin
                    n_o2 = w_j.c2;
                end else begin
                    n_vis = 1'b0;
                end
            end
        end else if (w_n.p1c2) begin
            if (!(b_p1_p2_c1 || w_n.p2c1)) begin
                if (b_p1_c1_p2) begin
                    n_o2 = w_j.c1;
                end else begin
                    n_vis = 1'b0;
                end
            end
        end else if (w_n.p2c1) begin
            if (!(b_p2_p1_c2 || w_n.p1c2)) begin
                if (b_p1_c2_p2) begin
                    n_o1 = w_j.p2;
                    n_o2 = w_j.c2;
                end else begin
                    n_vis = 1'b0;
                end
            end
        end else if (w_n.p2c2) begin
            if (!(b_p2_p1_c1 || w_n.p1c1)) begin
                if (b_p1_c1_p2) begin
                    n_o1 = w_j.c1;
                end else begin
                    n_vis = 1'b0;
                end
            end
        end else if (!b_p1_c1_p2) begin
            if (!b_p1_c2_p2) begin
                n_vis = b_c1_p1_c2;
            end else begin
                n_o2 = w_j.c2;
                if (!b_p2_p1_c1) begin
                    n_o1 = w_j.p2;
                end
            end
        end else begin
            n_o1 = w_j.c1;
            if (!b_p1_c2_p2) begin
                n_o2 = b_c1_p1_c2 ? w_j.p1 : w_j.p2;
            end else begin
                n_o2 = w_j.c2;
            end
        end
    end

    always_comb begin
        o_res.visible  = n_vis;
        o_res.clip_x_a = n_vis ? n_o1.x : '0;
        o_res.clip_y_a = n_vis ? n_o1.y : '0;
        o_res.clip_x_b = n_vis ? n_o2.x : '0;
        o_res.clip_y_b = n_vis ? n_o2.y : '0;
    end

    assign o_vld = r_vld[2];

endmodule

// ===== rtl/core/segment_window_clipper_core.sv =====
// ============================================================================
// segment_window_clipper_core: clips line segments against a window
// Signed fixed-point segments in, visible flag and clipped endpoints out.
// ============================================================================
//
//   Channel   Signals                               Moves
//   -------   -----------------------------------   --------------------------
//   in        i_vld, o_stall, i_data                one segment request
//   out       o_vld, i_stall, o_data                one clip result
//   config    i_cfg_we, i_cfg_addr, i_cfg_wdata     one window register write
//
// One request is taken per cycle while o_stall is low. Edge crossings come
// from dividers that yield one quotient bit per stage. Reset clears all valid
// bits and loads the window with zeros and the tolerance with 7. A stall on
// the output freezes the whole pipeline until the held result is taken; empty
// slots advance whenever the output is free.
module segment_window_clipper_core import swc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_stall,
    input  t_seg_in           i_data,
    output logic              o_vld,
    input  logic              i_stall,
    output t_seg_out          o_data,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CW-1:0]     i_cfg_wdata
);

    t_win      r_win;
    logic      w_adv;
    logic      w_line_vld;
    t_clip_job w_job;
    logic      w_seg_vld;
    t_seg_out  w_res;
    logic      r_out_vld;
    t_seg_out  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= '0;
            r_win.bottom <= '0;
            r_win.right  <= '0;
            r_win.top    <= '0;
            r_win.tol    <= TW'(7);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_WIN_LEFT:   r_win.left   <= i_cfg_wdata;
                REG_WIN_BOTTOM: r_win.bottom <= i_cfg_wdata;
                REG_WIN_RIGHT:  r_win.right  <= i_cfg_wdata;
                REG_WIN_TOP:    r_win.top    <= i_cfg_wdata;
                REG_TOLERANCE:  r_win.tol    <= i_cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register can take a value.
    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;

    swc_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (i_vld),
        .i_seg   (i_data),
        .i_win   (r_win),
        .o_vld   (w_line_vld),
        .o_job   (w_job)
    );

    swc_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_line_vld),
        .i_job   (w_job),
        .i_win   (r_win),
        .o_vld   (w_seg_vld),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_seg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule
